@@ hdl/arwf_pkg.sv @@
`default_nettype none

package arwf_pkg;

    localparam int WINDOW_BITS  = 2048;
    localparam int WINDOW_WORDS = 32;
    localparam int WORD_BITS    = 64;
    localparam int CNT_W        = 64;
    localparam int OP_W         = 2;
    localparam int BIT_W        = 6;
    localparam int IDX_W        = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;
    localparam int SRC_W        = 16;

    localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     addr;
        logic [WORD_BITS-1:0] data;
    } mem_wr_t;

endpackage

`default_nettype wire

@@ hdl/anti_replay_window_filter.sv @@
// Anti-replay filter over 64-bit packet counters with a 2048-bit seen window.
// Input stream: s_tuser carries the operation (check, commit, clear), s_tdata
// the counter. Output stream: one word per check, m_tdata bit 0 accepted,
// bit 1 stale. Commit and clear produce no output word.
// Steps from acceptance: a check reads its bitmap word if the counter lies in
// the stored window, then delivers its verdict through the output register;
// a commit inside the window is a read-modify-write of one bitmap word; a
// commit that slides the window rewrites every bitmap word, top word first,
// one word per cycle, after a priming read; a clear completes in the idle
// state; a first commit, a commit below the window and a jump of the window
// beyond its size end after evaluation. One word is in work at a time;
// s_tready is high whenever the filter is idle. The bitmap sits in a one-read,
// one-write memory with a registered read; per-word valid flags make unwritten
// words read as zero, so reset and clear take effect at once with no sweep.
// The verdict sits in an output register: a stalled receiver holds it there,
// and the filter still accepts the next word, stalling only if a second
// verdict is ready before the first is taken.
`default_nettype none

module anti_replay_window_filter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] counter
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [0] accepted, [1] stale, [7:2] zero
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIFF   = 3'd1;
    localparam logic [2:0] ST_EVAL   = 3'd2;
    localparam logic [2:0] ST_CHK_RD = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;
    localparam logic [2:0] ST_MARK   = 3'd5;
    localparam logic [2:0] ST_PRIME  = 3'd6;
    localparam logic [2:0] ST_SLIDE  = 3'd7;

    localparam int WB  = arwf_pkg::WORD_BITS;
    localparam int CW  = arwf_pkg::CNT_W;
    localparam int IW  = arwf_pkg::IDX_W;
    localparam int SW  = arwf_pkg::SRC_W;
    localparam int BW  = arwf_pkg::BIT_W;

    logic [2:0]                 state_reg, state_next;
    logic [arwf_pkg::OP_W-1:0]  op_reg, op_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic                       started_reg, started_next;
    logic [CW:0]                diff_reg, diff_next;
    logic [CW-1:0]              up_reg, up_next;
    logic [BW-1:0]              bs_reg, bs_next;
    logic signed [SW-1:0]       src_reg, src_next;
    logic [IW-1:0]              wr_idx_reg, wr_idx_next;
    logic [WB-1:0]              prev_reg, prev_next;
    logic                       res_acc_reg, res_acc_next;
    logic                       res_stale_reg, res_stale_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic                       m_acc_reg, m_acc_next;
    logic                       m_stale_reg, m_stale_next;

    arwf_pkg::mem_rd_t          bm_rd;
    arwf_pkg::mem_wr_t          bm_wr;
    logic                       bm_clear;
    logic [WB-1:0]              rd_data;

    logic                       far;
    logic                       in_store;
    logic                       up_far;
    logic signed [SW-1:0]       src0;
    logic [WB-1:0]              carry_in;

    arwf_bitmap u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (bm_clear),
        .rd      (bm_rd),
        .wr      (bm_wr),
        .rd_data (rd_data)
    );

    assign far      = diff_reg[CW-1:0] >= CW'(arwf_pkg::WINDOW_BITS);
    assign in_store = diff_reg[CW-1:BW] < (CW-BW)'(arwf_pkg::WINDOW_WORDS);
    assign up_far   = up_reg >= CW'(arwf_pkg::WINDOW_BITS);
    assign src0     = SW'(arwf_pkg::WINDOW_WORDS - 1) - SW'(up_reg[CW-1:BW]);
    assign carry_in = (bs_reg != '0) ? (rd_data >> (7'(WB) - {1'b0, bs_reg})) : '0;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        hi_next        = hi_reg;
        started_next   = started_reg;
        diff_next      = diff_reg;
        up_next        = up_reg;
        bs_next        = bs_reg;
        src_next       = src_reg;
        wr_idx_next    = wr_idx_reg;
        prev_next      = prev_reg;
        res_acc_next   = res_acc_reg;
        res_stale_next = res_stale_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_acc_next     = m_acc_reg;
        m_stale_next   = m_stale_reg;
        bm_rd          = '0;
        bm_wr          = '0;
        bm_clear       = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next  = s_tuser;
                    cnt_next = s_tdata;
                    case (s_tuser)
                        arwf_pkg::OP_CHECK,
                        arwf_pkg::OP_COMMIT:
                        begin
                            state_next = ST_DIFF;
                        end
                        arwf_pkg::OP_CLEAR:
                        begin
                            started_next = 1'b0;
                            hi_next      = '0;
                            bm_clear     = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_DIFF:
            begin
                // diff_next[CW] set means counter above highest
                diff_next  = {1'b0, hi_reg} - {1'b0, cnt_reg};
                up_next    = cnt_reg - hi_reg;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                if (op_reg == arwf_pkg::OP_CHECK)
                begin
                    state_next     = ST_RESULT;
                    res_acc_next   = 1'b1;
                    res_stale_next = 1'b0;
                    if (started_reg && !diff_reg[CW])
                    begin
                        if (far)
                        begin
                            res_acc_next   = 1'b0;
                            res_stale_next = 1'b1;
                        end
                        else if (in_store)
                        begin
                            bm_rd.en   = 1'b1;
                            bm_rd.addr = diff_reg[BW +: IW];
                            state_next = ST_CHK_RD;
                        end
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                    if (!started_reg || (diff_reg[CW] && up_far))
                    begin
                        bm_clear     = 1'b1;
                        bm_wr.en     = 1'b1;
                        bm_wr.addr   = '0;
                        bm_wr.data   = WB'(1);
                        hi_next      = cnt_reg;
                        started_next = 1'b1;
                    end
                    else if (diff_reg[CW])
                    begin
                        hi_next    = cnt_reg;
                        bs_next    = up_reg[BW-1:0];
                        bm_rd.en   = !src0[SW-1];
                        bm_rd.addr = src0[IW-1:0];
                        src_next   = src0 - SW'(1);
                        state_next = ST_PRIME;
                    end
                    else if (!far && in_store)
                    begin
                        bm_rd.en   = 1'b1;
                        bm_rd.addr = diff_reg[BW +: IW];
                        state_next = ST_MARK;
                    end
                end
            end

            ST_CHK_RD:
            begin
                res_acc_next   = !rd_data[diff_reg[BW-1:0]];
                res_stale_next = 1'b0;
                state_next     = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_acc_next    = res_acc_reg;
                    m_stale_next  = res_stale_reg;
                    state_next    = ST_IDLE;
                end
            end

            ST_MARK:
            begin
                bm_wr.en   = 1'b1;
                bm_wr.addr = diff_reg[BW +: IW];
                bm_wr.data = rd_data | (WB'(1) << diff_reg[BW-1:0]);
                state_next = ST_IDLE;
            end

            ST_PRIME:
            begin
                prev_next   = rd_data;
                bm_rd.en    = !src_reg[SW-1];
                bm_rd.addr  = src_reg[IW-1:0];
                src_next    = src_reg - SW'(1);
                wr_idx_next = IW'(arwf_pkg::WINDOW_WORDS - 1);
                state_next  = ST_SLIDE;
            end

            ST_SLIDE:
            begin
                // new[i] = old[i-ws] << bs | old[i-ws-1] >> (64-bs), top word first
                bm_wr.en    = 1'b1;
                bm_wr.addr  = wr_idx_reg;
                bm_wr.data  = (prev_reg << bs_reg) | carry_in;
                prev_next   = rd_data;
                bm_rd.en    = !src_reg[SW-1];
                bm_rd.addr  = src_reg[IW-1:0];
                src_next    = src_reg - SW'(1);
                wr_idx_next = wr_idx_reg - IW'(1);
                if (wr_idx_reg == '0)
                begin
                    bm_wr.data = (prev_reg << bs_reg) | carry_in | WB'(1);
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            hi_reg       <= '0;
            started_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hi_reg       <= hi_next;
            started_reg  <= started_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        cnt_reg       <= cnt_next;
        diff_reg      <= diff_next;
        up_reg        <= up_next;
        bs_reg        <= bs_next;
        src_reg       <= src_next;
        wr_idx_reg    <= wr_idx_next;
        prev_reg      <= prev_next;
        res_acc_reg   <= res_acc_next;
        res_stale_reg <= res_stale_next;
        m_acc_reg     <= m_acc_next;
        m_stale_reg   <= m_stale_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_stale_reg, m_acc_reg};

    a_stale_rejects: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("stale verdict marked as accepted");

    a_slide_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SLIDE && !src_reg[SW-1]) |-> (src_reg[IW-1:0] != wr_idx_reg))
        else $error("slide reads the word it writes");

    a_clear_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == arwf_pkg::OP_CLEAR) |=> !started_reg)
        else $error("clear left the filter started");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_RESULT))
        else $error("output word raised outside result stage");

endmodule

`default_nettype wire

@@ hdl/arwf_bitmap.sv @@
`default_nettype none

module arwf_bitmap (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           clear,
    input  wire arwf_pkg::mem_rd_t              rd,
    input  wire arwf_pkg::mem_wr_t              wr,
    output logic [arwf_pkg::WORD_BITS-1:0]      rd_data
);

    logic [arwf_pkg::WORD_BITS-1:0]    mem [arwf_pkg::WINDOW_WORDS];
    logic [arwf_pkg::WORD_BITS-1:0]    q_reg;
    logic                              q_ok_reg;
    logic [arwf_pkg::WINDOW_WORDS-1:0] valid_reg;
    logic [arwf_pkg::WINDOW_WORDS-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            q_reg <= mem[rd.addr];
        end
    end

    // word not written since clear reads as zero
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            q_ok_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            q_ok_reg  <= rd.en && valid_reg[rd.addr];
        end
    end

    assign rd_data = q_ok_reg ? q_reg : '0;

endmodule

`default_nettype wire

@@ test/anti_replay_window_filter_test.sv @@
`timescale 1ns / 1ps

module anti_replay_window_filter_test;

    localparam logic [arwf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [63:0] ALL_ONES    = '1;
    localparam int          STORE_BITS  = arwf_pkg::WINDOW_WORDS * arwf_pkg::WORD_BITS;
    localparam int          PHASE_ITEMS = 270;
    localparam int          HOLD_AT     = 90;
    localparam int          HOLD_CYCLES = 300;
    localparam int          LIMIT       = 400_000;
    localparam int          DRAIN       = 48;

    class replay_scoreboard;
        bit [63:0]           hi;
        bit [STORE_BITS-1:0] seen_bits;
        bit                  started;
        bit [1:0]            verdicts_due[$];
        int                  errors;
        int                  n_check, n_commit, n_clear, n_replay, n_stale;

        function void clear_state();
            hi        = '0;
            seen_bits = '0;
            started   = 1'b0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch at %0t: %s", $time, msg);
        endfunction

        // verdict bits: [0] accepted, [1] stale
        function void note_word(logic [arwf_pkg::OP_W-1:0] op, logic [63:0] cnt);
            bit [63:0] gap;
            bit        acc;
            bit        st;
            case (op)
                arwf_pkg::OP_CHECK:
                begin
                    acc = 1'b1;
                    st  = 1'b0;
                    if (started && cnt <= hi)
                    begin
                        gap = hi - cnt;
                        if (gap >= arwf_pkg::WINDOW_BITS)
                        begin
                            acc = 1'b0;
                            st  = 1'b1;
                        end
                        else if (gap < STORE_BITS && seen_bits[gap])
                            acc = 1'b0;
                    end
                    n_check++;
                    if (!acc && !st)
                        n_replay++;
                    if (st)
                        n_stale++;
                    verdicts_due.push_back({st, acc});
                end
                arwf_pkg::OP_COMMIT:
                begin
                    n_commit++;
                    if (!started)
                    begin
                        seen_bits    = '0;
                        seen_bits[0] = 1'b1;
                        hi           = cnt;
                        started      = 1'b1;
                    end
                    else if (cnt > hi)
                    begin
                        gap = cnt - hi;
                        if (gap < arwf_pkg::WINDOW_BITS)
                            seen_bits = seen_bits << gap;
                        else
                            seen_bits = '0;
                        seen_bits[0] = 1'b1;
                        hi           = cnt;
                    end
                    else
                    begin
                        gap = hi - cnt;
                        if (gap < arwf_pkg::WINDOW_BITS && gap < STORE_BITS)
                            seen_bits[gap] = 1'b1;
                    end
                end
                arwf_pkg::OP_CLEAR:
                begin
                    n_clear++;
                    clear_state();
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_verdict(logic [7:0] data);
            bit [1:0] want;
            if (verdicts_due.size() == 0)
            begin
                flag($sformatf("unexpected word m_tdata=%h", data));
                return;
            end
            want = verdicts_due.pop_front();
            if (data[0] !== want[0] || data[1] !== want[1])
                flag($sformatf("accepted exp %0b got %0b, stale exp %0b got %0b",
                               want[0], data[0], want[1], data[1]));
        endfunction
    endclass

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [63:0]      s_tdata  = '0;
    logic [1:0]       s_tuser  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;

    replay_scoreboard sb;
    int               send_idle  = 0;
    int               stall_pct  = 0;
    int               n_accepted = 0;
    int               hold_left  = 0;
    bit               hold_done  = 1'b0;
    int               cycles     = 0;

    anti_replay_window_filter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[anti_replay_window_filter] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            sb.note_word(s_tuser, s_tdata);
            n_accepted++;
        end
        if (rst_n && m_tvalid && m_tready)
            sb.check_verdict(m_tdata);
    end

    // receiver; one long hold-off early on to back the filter up
    always @(posedge clk)
    begin
        if (!hold_done && n_accepted >= HOLD_AT)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_word(input logic [1:0] op, input logic [63:0] cnt);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= cnt;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic [63:0] pick_gap();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 64'($urandom_range(0, 70));
            4:          return 64'($urandom_range(0, 2047));
            5:          return 64'($urandom_range(2040, 2056));
            6:          return 64'(64 * $urandom_range(0, 33) + 63 * $urandom_range(0, 1));
            7:          return {$urandom, $urandom};
            8:          return 64'($urandom_range(1, 200));
            default:    return 64'($urandom_range(2048, 10000));
        endcase
    endfunction

    task automatic random_word(output logic [1:0] op, output logic [63:0] cnt);
        int r;
        r = $urandom_range(0, 999);
        if (r < 25)
        begin
            op  = arwf_pkg::OP_CLEAR;
            cnt = {$urandom, $urandom};
        end
        else if (r < 45)
        begin
            op  = OP_UNUSED;
            cnt = {$urandom, $urandom};
        end
        else if (r < 80)
        begin
            op  = $urandom_range(0, 1) ? arwf_pkg::OP_COMMIT : arwf_pkg::OP_CHECK;
            cnt = {$urandom, $urandom};
        end
        else if (r < 450)
        begin
            op  = arwf_pkg::OP_COMMIT;
            cnt = ($urandom_range(0, 99) < 60) ? sb.hi + pick_gap() : sb.hi - pick_gap();
        end
        else
        begin
            op  = arwf_pkg::OP_CHECK;
            cnt = ($urandom_range(0, 99) < 35) ? sb.hi + pick_gap() : sb.hi - pick_gap();
        end
    endtask

    task automatic directed_words();
        send_word(arwf_pkg::OP_CHECK,  64'd0);
        send_word(arwf_pkg::OP_CHECK,  ALL_ONES);
        send_word(arwf_pkg::OP_COMMIT, 64'd0);
        send_word(arwf_pkg::OP_CHECK,  64'd0);
        send_word(arwf_pkg::OP_CHECK,  64'd1);
        send_word(arwf_pkg::OP_COMMIT, 64'd2047);
        send_word(arwf_pkg::OP_CHECK,  64'd0);        // far edge of window, seen
        send_word(arwf_pkg::OP_COMMIT, 64'd2048);
        send_word(arwf_pkg::OP_CHECK,  64'd0);        // just below window
        send_word(arwf_pkg::OP_CHECK,  64'd1);
        send_word(arwf_pkg::OP_COMMIT, 64'd1);
        send_word(arwf_pkg::OP_CHECK,  64'd1);
        send_word(arwf_pkg::OP_COMMIT, 64'd0);        // below window, dropped
        send_word(arwf_pkg::OP_COMMIT, 64'd2112);     // whole-word slide
        send_word(arwf_pkg::OP_CHECK,  64'd2048);
        send_word(arwf_pkg::OP_COMMIT, 64'd7112);     // jump past window
        send_word(arwf_pkg::OP_CHECK,  64'd2112);
        send_word(arwf_pkg::OP_CHECK,  64'd7111);
        send_word(OP_UNUSED,           64'd7112);
        send_word(arwf_pkg::OP_CHECK,  64'd7112);
        send_word(arwf_pkg::OP_CLEAR,  64'd0);
        send_word(arwf_pkg::OP_CHECK,  64'd0);
        send_word(arwf_pkg::OP_COMMIT, ALL_ONES);
        send_word(arwf_pkg::OP_CHECK,  64'd0);
        send_word(arwf_pkg::OP_CHECK,  ALL_ONES);
        send_word(arwf_pkg::OP_COMMIT, ALL_ONES - 64'd100);
        send_word(arwf_pkg::OP_CHECK,  ALL_ONES - 64'd100);
    endtask

    int send_tbl[4]  = '{0, 64, 0, 36};
    int stall_tbl[4] = '{0, 0, 64, 36};

    initial
    begin
        logic [1:0]  op;
        logic [63:0] cnt;
        int          n;
        sb = new();
        sb.clear_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();

        for (int p = 0; p < 4; p++)
        begin
            send_idle = send_tbl[p];
            stall_pct = stall_tbl[p];
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                random_word(op, cnt);
                send_word(op, cnt);
                if (op != OP_UNUSED)
                    n++;
            end
        end
        s_tvalid <= 1'b0;
        stall_pct = 0;

        while (sb.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (sb.verdicts_due.size() != 0)
            sb.flag("verdicts still outstanding at end");

        $display("covered %0d checks (%0d replays, %0d stale), %0d commits, %0d clears",
                 sb.n_check, sb.n_replay, sb.n_stale, sb.n_commit, sb.n_clear);
        $display("idle mixes: none, sender, receiver, both; %0d-cycle hold; %0d errors",
                 HOLD_CYCLES, sb.errors);
        if (sb.errors == 0)
            $display("[anti_replay_window_filter] OK");
        else
            $display("[anti_replay_window_filter] ERROR");
        $finish;
    end

endmodule
